/* rtl/core/mpsl_pkg.sv */
// Package with the shared types and codes of the motor PWM slew limiter.
`timescale 1ns / 1ps
`default_nettype none

package mpsl_pkg;

    typedef logic [7:0]  duty_t;
    typedef logic [15:0] limit_t;
    typedef logic [1:0]  action_t;

    // Command codes of the action field.
    localparam action_t ACT_TICK   = 2'd0;
    localparam action_t ACT_TARGET = 2'd1;
    localparam action_t ACT_PING   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SLEW_STEP     = 2'd0;
    localparam logic [1:0] REG_MAX_DUTY      = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd2;

    localparam duty_t  SLEW_STEP_RST     = 8'd4;
    localparam duty_t  MAX_DUTY_RST      = 8'd255;
    localparam limit_t TIMEOUT_LIMIT_RST = 16'd100;

    localparam logic [6:0] SLOW_TOP     = 7'd99;
    localparam logic [6:0] FAST_TOP     = 7'd9;
    localparam logic [2:0] PRESCALE_TOP = 3'd4;

    localparam int OUT_MOTORS = 4;

endpackage

`default_nettype wire

/* rtl/core/motor_pwm_slew_limiter_with_watchdog.sv */
// Motor PWM slew-rate limiter with communication watchdog, top level.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------------------------
//  cmd     | cmd_valid/cmd_stall| action, motor_sel, want_reverse, want_duty
//  res     | res_valid/res_stall| dir_m0..3, duty_m0..3, timed_out, led_on
//  apb     | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// The motor state and the result register are both loaded at the edge that
// accepts a command.
// A new command is taken in every cycle unless a result waits with res_stall
// high. Reset clears all motor, watchdog and LED state and loads the register
// defaults. Stalling the result side holds the result register and the command side.
`timescale 1ns / 1ps
`default_nettype none

module motor_pwm_slew_limiter_with_watchdog #(
    parameter int MOTORS = 4
) (
    input  wire                  clk,
    input  wire                  rst_n,
    // command channel
    input  wire                  cmd_valid,
    output logic                 cmd_stall,
    input  wire  mpsl_pkg::action_t action,
    input  wire  [1:0]           motor_sel,
    input  wire                  want_reverse,
    input  wire  mpsl_pkg::duty_t want_duty,
    // result channel
    output logic                 res_valid,
    input  wire                  res_stall,
    output logic                 dir_m0,
    output logic                 dir_m1,
    output logic                 dir_m2,
    output logic                 dir_m3,
    output mpsl_pkg::duty_t      duty_m0,
    output mpsl_pkg::duty_t      duty_m1,
    output mpsl_pkg::duty_t      duty_m2,
    output mpsl_pkg::duty_t      duty_m3,
    output logic                 timed_out,
    output logic                 led_on,
    // configuration port
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [3:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    import mpsl_pkg::*;

    // Configuration registers
    duty_t  slew_step_reg;
    duty_t  max_duty_reg;
    limit_t timeout_limit_reg;

    // Motor state
    duty_t  actual_duty_reg [MOTORS];
    logic   actual_dir_reg  [MOTORS];
    duty_t  target_duty_reg [MOTORS];
    logic   target_dir_reg  [MOTORS];
    duty_t  actual_duty_next[MOTORS];
    logic   actual_dir_next [MOTORS];
    duty_t  target_duty_next[MOTORS];
    logic   target_dir_next [MOTORS];

    // Watchdog and LED state
    logic [2:0] tick_prescale_reg, tick_prescale_next;
    logic [6:0] blink_count_reg, blink_count_next;
    logic       led_level_reg, led_level_next;
    limit_t     silence_count_reg, silence_count_next;
    logic       timeout_flag_reg, timeout_flag_next;

    // Result register
    logic       res_valid_reg;
    logic [3:0] res_dir_reg;
    duty_t      res_duty_reg [OUT_MOTORS];
    logic       res_timed_out_reg;
    logic       res_led_reg;

    logic   cmd_accept;
    logic   cfg_write;
    duty_t  clipped_want;
    logic   [16:0] silence_inc;
    logic   [6:0]  blink_top;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign cmd_stall  = res_valid_reg && res_stall;
    assign cmd_accept = cmd_valid && !cmd_stall;

    always_comb
    begin
        prdata = 32'd0;
        case (paddr[3:2])
            REG_SLEW_STEP:     prdata = {24'd0, slew_step_reg};
            REG_MAX_DUTY:      prdata = {24'd0, max_duty_reg};
            REG_TIMEOUT_LIMIT: prdata = {16'd0, timeout_limit_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slew_step_reg     <= SLEW_STEP_RST;
            max_duty_reg      <= MAX_DUTY_RST;
            timeout_limit_reg <= TIMEOUT_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SLEW_STEP:     slew_step_reg     <= pwdata[7:0];
                REG_MAX_DUTY:      max_duty_reg      <= pwdata[7:0];
                REG_TIMEOUT_LIMIT: timeout_limit_reg <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    assign clipped_want = (want_duty > max_duty_reg) ? max_duty_reg : want_duty;
    assign silence_inc  = {1'b0, silence_count_reg} + 17'd1;
    assign blink_top    = timeout_flag_reg ? FAST_TOP : SLOW_TOP;

    // Per-motor slew step and target writes.
    always_comb
    begin
        logic [8:0] sum;
        logic [8:0] diff;
        duty_t      stepped;
        for (int m = 0; m < MOTORS; m++)
        begin
            actual_duty_next[m] = actual_duty_reg[m];
            actual_dir_next[m]  = actual_dir_reg[m];
            target_duty_next[m] = target_duty_reg[m];
            target_dir_next[m]  = target_dir_reg[m];
            sum  = {1'b0, actual_duty_reg[m]} + {1'b0, slew_step_reg};
            diff = {1'b0, actual_duty_reg[m]} - {1'b0, slew_step_reg};
            stepped = actual_duty_reg[m];
            if (action == ACT_TICK)
            begin
                if (timeout_flag_reg)
                begin
                    actual_duty_next[m] = 8'd0;
                end
                else if (target_dir_reg[m] != actual_dir_reg[m])
                begin
                    // Reverse request: ramp down first, flip once the duty is zero.
                    stepped = diff[8] ? 8'd0 : diff[7:0];
                    actual_duty_next[m] = stepped;
                    if (stepped == 8'd0)
                        actual_dir_next[m] = target_dir_reg[m];
                end
                else if (actual_duty_reg[m] > target_duty_reg[m])
                begin
                    if (diff[8])
                        stepped = 8'd0;
                    else if (diff[7:0] > max_duty_reg)
                        stepped = max_duty_reg;
                    else
                        stepped = diff[7:0];
                    actual_duty_next[m] = (stepped < target_duty_reg[m]) ?
                                          target_duty_reg[m] : stepped;
                end
                else if (actual_duty_reg[m] < target_duty_reg[m])
                begin
                    stepped = (sum > {1'b0, max_duty_reg}) ? max_duty_reg : sum[7:0];
                    actual_duty_next[m] = (stepped > target_duty_reg[m]) ?
                                          target_duty_reg[m] : stepped;
                end
            end
            else if (action == ACT_TARGET && int'(motor_sel) == m)
            begin
                target_dir_next[m]  = want_reverse;
                target_duty_next[m] = clipped_want;
            end
        end
    end

    // Prescaler, blink counter and watchdog.
    always_comb
    begin
        tick_prescale_next = tick_prescale_reg;
        blink_count_next   = blink_count_reg;
        led_level_next     = led_level_reg;
        silence_count_next = silence_count_reg;
        timeout_flag_next  = timeout_flag_reg;
        case (action)
            ACT_TICK:
            begin
                if (tick_prescale_reg == 3'd0)
                begin
                    if (blink_count_reg == 7'd0)
                        led_level_next = !led_level_reg;
                    blink_count_next = (blink_count_reg >= blink_top) ? 7'd0 :
                                       blink_count_reg + 7'd1;
                    if (silence_inc >= {1'b0, timeout_limit_reg})
                    begin
                        silence_count_next = timeout_limit_reg;
                        timeout_flag_next  = 1'b1;
                    end
                    else
                    begin
                        silence_count_next = silence_inc[15:0];
                        timeout_flag_next  = 1'b0;
                    end
                end
                tick_prescale_next = (tick_prescale_reg >= PRESCALE_TOP) ? 3'd0 :
                                     tick_prescale_reg + 3'd1;
            end
            ACT_PING:
            begin
                // The flag itself drops only at the next watchdog update.
                silence_count_next = 16'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MOTORS; m++)
            begin
                actual_duty_reg[m] <= 8'd0;
                actual_dir_reg[m]  <= 1'b0;
                target_duty_reg[m] <= 8'd0;
                target_dir_reg[m]  <= 1'b0;
            end
            tick_prescale_reg <= 3'd0;
            blink_count_reg   <= 7'd0;
            led_level_reg     <= 1'b0;
            silence_count_reg <= 16'd0;
            timeout_flag_reg  <= 1'b0;
        end
        else if (cmd_accept)
        begin
            for (int m = 0; m < MOTORS; m++)
            begin
                actual_duty_reg[m] <= actual_duty_next[m];
                actual_dir_reg[m]  <= actual_dir_next[m];
                target_duty_reg[m] <= target_duty_next[m];
                target_dir_reg[m]  <= target_dir_next[m];
            end
            tick_prescale_reg <= tick_prescale_next;
            blink_count_reg   <= blink_count_next;
            led_level_reg     <= led_level_next;
            silence_count_reg <= silence_count_next;
            timeout_flag_reg  <= timeout_flag_next;
        end
    end

    // Result register: valid is control state, the payload loads on each transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd_accept)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            for (int m = 0; m < OUT_MOTORS; m++)
            begin
                if (m < MOTORS && !timeout_flag_next)
                begin
                    res_dir_reg[m]  <= actual_dir_next[m];
                    res_duty_reg[m] <= actual_duty_next[m];
                end
                else
                begin
                    res_dir_reg[m]  <= 1'b0;
                    res_duty_reg[m] <= 8'd0;
                end
            end
            res_timed_out_reg <= timeout_flag_next;
            res_led_reg       <= led_level_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign dir_m0    = res_dir_reg[0];
    assign dir_m1    = res_dir_reg[1];
    assign dir_m2    = res_dir_reg[2];
    assign dir_m3    = res_dir_reg[3];
    assign duty_m0   = res_duty_reg[0];
    assign duty_m1   = res_duty_reg[1];
    assign duty_m2   = res_duty_reg[2];
    assign duty_m3   = res_duty_reg[3];
    assign timed_out = res_timed_out_reg;
    assign led_on    = res_led_reg;

    // While timed out every reported motor is stopped and driven forward.
    a_stop_when_timed_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && timed_out |-> duty_m0 == 8'd0 && duty_m1 == 8'd0 &&
        duty_m2 == 8'd0 && duty_m3 == 8'd0 && !dir_m0 && !dir_m1 && !dir_m2 && !dir_m3)
        else $error("motor driven while timed out");

    // Every accepted command yields a result on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> res_valid_reg)
        else $error("accepted command produced no result");

    a_prescale_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_prescale_reg <= PRESCALE_TOP && blink_count_reg <= SLOW_TOP)
        else $error("prescaler or blink counter out of range");

    // A duty only changes on a tick command (checked on motor 0).
    a_duty_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept && action != ACT_TICK |=> $stable(actual_duty_reg[0]))
        else $error("duty changed outside a tick");

endmodule

`default_nettype wire
